>>> hdl/sps_pkg.sv
`default_nettype none

package sps_pkg;

    // width of a decoded syntax element value, values above it saturate
    localparam int VAL_W = 32;
    localparam logic [VAL_W-1:0] VAL_MAX = '1;

    // macroblock edge is 16 pixels
    localparam int MB_LOG2 = 4;
    // cropped size arithmetic: (value + 1) * 16 * 2 needs VAL_W + 6 bits
    localparam int SIZE_W = VAL_W + MB_LOG2 + 2;
    localparam int PIX_W = 16;

    // start codes and NAL type
    localparam logic [31:0] START_CODE4 = 32'h0000_0001;
    localparam logic [23:0] START_CODE3 = 24'h00_0001;
    localparam logic [4:0] NAL_TYPE_SPS = 5'd7;

    // result status codes
    localparam logic [1:0] STAT_OK = 2'd0;
    localparam logic [1:0] STAT_BAD = 2'd1;
    localparam logic [1:0] STAT_SHORT = 2'd2;

    // element values with a meaning
    localparam logic [1:0] CHROMA_420 = 2'd1;
    localparam logic [1:0] CHROMA_422 = 2'd2;
    localparam logic [1:0] CHROMA_444 = 2'd3;
    localparam logic [1:0] CHROMA_DEFAULT = CHROMA_420;
    localparam logic [1:0] POC_TYPE1 = 2'd1;

    // saturation limits of the reported fields
    localparam logic [VAL_W-1:0] SPSID_MAX = 32'd31;
    localparam logic [VAL_W-1:0] CHROMA_MAX = 32'd3;
    localparam logic [VAL_W-1:0] DEPTH_MAX = 32'd14;
    localparam logic [VAL_W-1:0] POC_MAX = 32'd2;
    localparam logic [VAL_W-1:0] MAXREF_MAX = 32'd255;

    // element length codes of a microcode word
    localparam logic [3:0] EXPG = 4'd0;
    localparam logic [3:0] FIX1 = 4'd1;
    localparam logic [3:0] FIX8 = 4'd8;

    // SPS syntax steps, in bitstream order
    typedef enum logic [4:0] {
        ST_PROFILE, ST_CONSTR, ST_LEVEL, ST_SPSID, ST_CHROMA, ST_SEPCOL,
        ST_LUMA, ST_CHRD, ST_BYPASS, ST_SCALING, ST_LOG2FN, ST_POC,
        ST_LOG2POC, ST_DZERO, ST_OFFNR, ST_OFFTB, ST_NCYC, ST_CYC,
        ST_MAXREF, ST_GAPS, ST_WMBS, ST_HMAPS, ST_FMO, ST_MBAFF, ST_D8,
        ST_CROPF, ST_CL, ST_CR, ST_CT, ST_CB, ST_VUI, ST_DONE
    } t_step;

    // where a finished element goes
    typedef enum logic [4:0] {
        D_NONE, D_PROFILE, D_LEVEL, D_SPSID, D_CHROMA, D_LUMA, D_CHRD,
        D_POC, D_MAXREF, D_WMBS, D_HMAPS, D_FRAME, D_SKIP, D_CL, D_CR,
        D_CT, D_CB
    } t_dest;

    // how the step counter moves when an element finishes
    typedef enum logic [2:0] {
        C_NEXT, C_JUMP, C_ZERO, C_NONZERO, C_NOTHIGH, C_NE3, C_POC, C_CYC
    } t_cond;

    typedef struct packed {
        logic [3:0] nbits;
        t_dest      dest;
        t_cond      cond;
        t_step      target;
    } t_uop;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  profile_idc;
        logic [7:0]  level_idc;
        logic [4:0]  sps_id;
        logic [1:0]  chroma_format;
        logic [3:0]  luma_depth_minus8;
        logic [3:0]  chroma_depth_minus8;
        logic [1:0]  poc_type;
        logic [7:0]  max_ref_frames;
        logic        frame_only;
        logic [15:0] pic_width;
        logic [15:0] pic_height;
    } t_out;

    // decoded fields held by the sequencer
    typedef struct packed {
        logic [7:0]       profile_idc;
        logic [7:0]       level_idc;
        logic [4:0]       sps_id;
        logic [1:0]       chroma_format;
        logic [3:0]       luma_depth_minus8;
        logic [3:0]       chroma_depth_minus8;
        logic [1:0]       poc_type;
        logic [7:0]       max_ref_frames;
        logic             frame_only;
        logic [VAL_W-1:0] width_mbs;
        logic [VAL_W-1:0] height_maps;
        logic [VAL_W-1:0] crop_left;
        logic [VAL_W-1:0] crop_right;
        logic [VAL_W-1:0] crop_top;
        logic [VAL_W-1:0] crop_bottom;
    } t_fields;

    function automatic logic is_high_profile(input logic [7:0] p);
        return p inside {8'd100, 8'd110, 8'd122, 8'd244, 8'd44, 8'd83, 8'd86,
                         8'd118, 8'd128, 8'd138, 8'd139, 8'd134, 8'd135};
    endfunction

    function automatic logic [VAL_W-1:0] sat_val(input logic [VAL_W-1:0] v,
                                                 input logic [VAL_W-1:0] lim);
        return (v > lim) ? lim : v;
    endfunction

    // microcode ROM: one control word per syntax step
    function automatic t_uop uop_rom(input t_step step);
        t_uop u;
        u = '{EXPG, D_NONE, C_NEXT, ST_DONE};
        case (step)
            ST_PROFILE: u = '{FIX8, D_PROFILE, C_NEXT,    ST_DONE};
            ST_CONSTR:  u = '{FIX8, D_NONE,    C_NEXT,    ST_DONE};
            ST_LEVEL:   u = '{FIX8, D_LEVEL,   C_NEXT,    ST_DONE};
            ST_SPSID:   u = '{EXPG, D_SPSID,   C_NOTHIGH, ST_LOG2FN};
            ST_CHROMA:  u = '{EXPG, D_CHROMA,  C_NE3,     ST_LUMA};
            ST_SEPCOL:  u = '{FIX1, D_NONE,    C_NEXT,    ST_DONE};
            ST_LUMA:    u = '{EXPG, D_LUMA,    C_NEXT,    ST_DONE};
            ST_CHRD:    u = '{EXPG, D_CHRD,    C_NEXT,    ST_DONE};
            ST_BYPASS:  u = '{FIX1, D_NONE,    C_NEXT,    ST_DONE};
            ST_SCALING: u = '{FIX1, D_NONE,    C_NEXT,    ST_DONE};
            ST_LOG2FN:  u = '{EXPG, D_NONE,    C_NEXT,    ST_DONE};
            ST_POC:     u = '{EXPG, D_POC,     C_POC,     ST_MAXREF};
            ST_LOG2POC: u = '{EXPG, D_NONE,    C_JUMP,    ST_MAXREF};
            ST_DZERO:   u = '{FIX1, D_NONE,    C_NEXT,    ST_DONE};
            ST_OFFNR:   u = '{EXPG, D_NONE,    C_NEXT,    ST_DONE};
            ST_OFFTB:   u = '{EXPG, D_NONE,    C_NEXT,    ST_DONE};
            ST_NCYC:    u = '{EXPG, D_SKIP,    C_ZERO,    ST_MAXREF};
            ST_CYC:     u = '{EXPG, D_NONE,    C_CYC,     ST_CYC};
            ST_MAXREF:  u = '{EXPG, D_MAXREF,  C_NEXT,    ST_DONE};
            ST_GAPS:    u = '{FIX1, D_NONE,    C_NEXT,    ST_DONE};
            ST_WMBS:    u = '{EXPG, D_WMBS,    C_NEXT,    ST_DONE};
            ST_HMAPS:   u = '{EXPG, D_HMAPS,   C_NEXT,    ST_DONE};
            ST_FMO:     u = '{FIX1, D_FRAME,   C_NONZERO, ST_D8};
            ST_MBAFF:   u = '{FIX1, D_NONE,    C_NEXT,    ST_DONE};
            ST_D8:      u = '{FIX1, D_NONE,    C_NEXT,    ST_DONE};
            ST_CROPF:   u = '{FIX1, D_NONE,    C_ZERO,    ST_VUI};
            ST_CL:      u = '{EXPG, D_CL,      C_NEXT,    ST_DONE};
            ST_CR:      u = '{EXPG, D_CR,      C_NEXT,    ST_DONE};
            ST_CT:      u = '{EXPG, D_CT,      C_NEXT,    ST_DONE};
            ST_CB:      u = '{EXPG, D_CB,      C_NEXT,    ST_DONE};
            ST_VUI:     u = '{FIX1, D_NONE,    C_NEXT,    ST_DONE};
            default:    u = '{EXPG, D_NONE,    C_NEXT,    ST_DONE};
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

>>> hdl/sps_seq.sv
`default_nettype none

// Microcoded SPS walker: one payload bit per valid cycle; decodes fixed
// and Exp-Golomb elements and steps through the syntax table.
module sps_seq #(
    parameter int CODE_BITS = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic             i_bit_valid,
    input  wire logic             i_bit,
    output sps_pkg::t_fields      o_fields,
    output logic                  o_done
);

    localparam int VW = sps_pkg::VAL_W;
    localparam int ACC_W = CODE_BITS + 1;
    localparam int LZ_W = $clog2(CODE_BITS + 1);
    localparam int RAW_W = (ACC_W > VW) ? ACC_W : VW + 1;

    sps_pkg::t_step   r_step, n_step;
    logic [ACC_W-1:0] r_acc, n_acc;
    logic [LZ_W-1:0]  r_lz, n_lz;
    logic [VW-1:0]    r_skip, n_skip;
    sps_pkg::t_fields r_fld, n_fld;

    sps_pkg::t_uop    w_uop;
    sps_pkg::t_step   w_step_inc;
    logic             w_eg;
    logic             w_elem_done;
    logic [ACC_W-1:0] w_acc_sh;
    logic [ACC_W-1:0] w_raw;
    logic [RAW_W-1:0] w_raw_x;
    logic [VW-1:0]    w_val;
    logic [VW-1:0]    w_skip_dec;

    // control word of the current step
    assign w_uop = sps_pkg::uop_rom(r_step);
    assign w_eg = (w_uop.nbits == sps_pkg::EXPG);
    assign w_acc_sh = {r_acc[ACC_W-2:0], i_bit};
    assign w_step_inc = sps_pkg::t_step'(r_step + 5'd1);
    assign w_skip_dec = r_skip - 1'b1;

    // element value, saturated to VAL_W bits
    assign w_raw = w_eg ? (n_acc - 1'b1) : n_acc;
    assign w_raw_x = RAW_W'(w_raw);
    assign w_val = (w_raw_x > RAW_W'(sps_pkg::VAL_MAX)) ? sps_pkg::VAL_MAX
                                                        : w_raw_x[VW-1:0];

    // bit-serial element decode
    always_comb begin
        n_acc = r_acc;
        n_lz = r_lz;
        w_elem_done = 1'b0;
        if (i_bit_valid && (r_step != sps_pkg::ST_DONE)) begin
            if (!w_eg) begin
                n_acc = w_acc_sh;
                n_lz = r_lz + 1'b1;
                w_elem_done = (({1'b0, r_lz} + 1'b1) >= (LZ_W + 1)'(w_uop.nbits));
            end else if (r_acc == '0) begin
                // prefix: count zeros until a one or the cap
                if (i_bit || (r_lz >= LZ_W'(CODE_BITS))) begin
                    n_acc = ACC_W'(1);
                    w_elem_done = (r_lz == '0);
                end else begin
                    n_lz = r_lz + 1'b1;
                end
            end else begin
                // suffix bits
                n_acc = w_acc_sh;
                n_lz = r_lz - 1'b1;
                w_elem_done = (r_lz == LZ_W'(1));
            end
        end
    end

    // field writes and step sequencing
    always_comb begin
        n_step = r_step;
        n_skip = r_skip;
        n_fld = r_fld;
        if (w_elem_done) begin
            case (w_uop.dest)
                sps_pkg::D_PROFILE: n_fld.profile_idc = w_val[7:0];
                sps_pkg::D_LEVEL:   n_fld.level_idc = w_val[7:0];
                sps_pkg::D_SPSID:
                    n_fld.sps_id = 5'(sps_pkg::sat_val(w_val, sps_pkg::SPSID_MAX));
                sps_pkg::D_CHROMA:
                    n_fld.chroma_format = 2'(sps_pkg::sat_val(w_val, sps_pkg::CHROMA_MAX));
                sps_pkg::D_LUMA:
                    n_fld.luma_depth_minus8 =
                        4'(sps_pkg::sat_val(w_val, sps_pkg::DEPTH_MAX));
                sps_pkg::D_CHRD:
                    n_fld.chroma_depth_minus8 =
                        4'(sps_pkg::sat_val(w_val, sps_pkg::DEPTH_MAX));
                sps_pkg::D_POC:
                    n_fld.poc_type = 2'(sps_pkg::sat_val(w_val, sps_pkg::POC_MAX));
                sps_pkg::D_MAXREF:
                    n_fld.max_ref_frames = 8'(sps_pkg::sat_val(w_val, sps_pkg::MAXREF_MAX));
                sps_pkg::D_WMBS:    n_fld.width_mbs = w_val;
                sps_pkg::D_HMAPS:   n_fld.height_maps = w_val;
                sps_pkg::D_FRAME:   n_fld.frame_only = w_val[0];
                sps_pkg::D_SKIP:    n_skip = w_val;
                sps_pkg::D_CL:      n_fld.crop_left = w_val;
                sps_pkg::D_CR:      n_fld.crop_right = w_val;
                sps_pkg::D_CT:      n_fld.crop_top = w_val;
                sps_pkg::D_CB:      n_fld.crop_bottom = w_val;
                default: begin
                end
            endcase

            case (w_uop.cond)
                sps_pkg::C_NEXT:    n_step = w_step_inc;
                sps_pkg::C_JUMP:    n_step = w_uop.target;
                sps_pkg::C_ZERO:
                    n_step = (w_val == '0) ? w_uop.target : w_step_inc;
                sps_pkg::C_NONZERO:
                    n_step = (w_val != '0) ? w_uop.target : w_step_inc;
                sps_pkg::C_NOTHIGH:
                    n_step = sps_pkg::is_high_profile(r_fld.profile_idc) ? w_step_inc
                                                                         : w_uop.target;
                sps_pkg::C_NE3:
                    n_step = (w_val != VW'(sps_pkg::CHROMA_444)) ? w_uop.target
                                                                 : w_step_inc;
                sps_pkg::C_POC: begin
                    // type 0 reads the lsb length, type 1 the offsets
                    if (w_val == '0) begin
                        n_step = w_step_inc;
                    end else if (w_val == VW'(sps_pkg::POC_TYPE1)) begin
                        n_step = sps_pkg::t_step'(r_step + 5'd2);
                    end else begin
                        n_step = w_uop.target;
                    end
                end
                sps_pkg::C_CYC: begin
                    n_skip = w_skip_dec;
                    n_step = (w_skip_dec != '0) ? w_uop.target : w_step_inc;
                end
                default: n_step = w_step_inc;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= sps_pkg::ST_PROFILE;
            r_acc <= '0;
            r_lz <= '0;
            r_skip <= '0;
            r_fld <= '0;
        end else if (i_start) begin
            r_step <= sps_pkg::ST_PROFILE;
            r_acc <= '0;
            r_lz <= '0;
            r_skip <= '0;
            r_fld <= '0;
            r_fld.chroma_format <= sps_pkg::CHROMA_DEFAULT;
        end else begin
            r_step <= n_step;
            r_acc <= w_elem_done ? '0 : n_acc;
            r_lz <= w_elem_done ? '0 : n_lz;
            r_skip <= n_skip;
            r_fld <= n_fld;
        end
    end

    assign o_fields = r_fld;
    assign o_done = (r_step == sps_pkg::ST_DONE);

endmodule

`default_nettype wire

>>> hdl/sps_size.sv
`default_nettype none

// Cropped picture size: two stages, terms first, then subtract and clamp.
module sps_size (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire sps_pkg::t_fields  i_fields,
    output logic                   o_done,
    output logic [15:0]            o_width,
    output logic [15:0]            o_height
);

    localparam int SW = sps_pkg::SIZE_W;
    localparam int PW = sps_pkg::PIX_W;

    logic          r_stage1, r_done;
    logic [SW-1:0] r_full_w, r_full_h, r_sub_w, r_sub_h;
    logic [PW-1:0] r_width, r_height;

    logic [SW-1:0] w_full_w, w_full_h, w_sum_w, w_sum_h, w_sub_w, w_sub_h;
    logic          w_cx2, w_cy2;
    logic [SW:0]   w_dw, w_dh;
    logic [PW-1:0] w_width, w_height;

    // stage 1: full size and crop amounts
    assign w_cx2 = (i_fields.chroma_format == sps_pkg::CHROMA_420) ||
                   (i_fields.chroma_format == sps_pkg::CHROMA_422);
    assign w_cy2 = (i_fields.chroma_format == sps_pkg::CHROMA_420);
    assign w_full_w = (SW'(i_fields.width_mbs) + 1'b1) << sps_pkg::MB_LOG2;
    assign w_full_h = i_fields.frame_only
                    ? ((SW'(i_fields.height_maps) + 1'b1) << sps_pkg::MB_LOG2)
                    : ((SW'(i_fields.height_maps) + 1'b1) << (sps_pkg::MB_LOG2 + 1));
    assign w_sum_w = SW'(i_fields.crop_left) + SW'(i_fields.crop_right);
    assign w_sum_h = SW'(i_fields.crop_top) + SW'(i_fields.crop_bottom);
    assign w_sub_w = w_cx2 ? (w_sum_w << 1) : w_sum_w;
    assign w_sub_h = (w_cy2 ? (w_sum_h << 1) : w_sum_h) << (i_fields.frame_only ? 0 : 1);

    // stage 2: subtract, borrow means clamp to zero, overflow saturates
    assign w_dw = {1'b0, r_full_w} - {1'b0, r_sub_w};
    assign w_dh = {1'b0, r_full_h} - {1'b0, r_sub_h};
    assign w_width = w_dw[SW] ? '0 : ((|w_dw[SW-1:PW]) ? '1 : w_dw[PW-1:0]);
    assign w_height = w_dh[SW] ? '0 : ((|w_dh[SW-1:PW]) ? '1 : w_dh[PW-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage1 <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_stage1 <= i_start;
            r_done <= r_stage1;
        end
        if (i_start) begin
            r_full_w <= w_full_w;
            r_full_h <= w_full_h;
            r_sub_w <= w_sub_w;
            r_sub_h <= w_sub_h;
        end
        if (r_stage1) begin
            r_width <= w_width;
            r_height <= w_height;
        end
    end

    assign o_done = r_done;
    assign o_width = r_width;
    assign o_height = r_height;

endmodule

`default_nettype wire

>>> hdl/h264_sps_header_parser.sv
// H.264 SPS header parser.
// Input channel (i_in_valid / o_in_ready / i_in_data): raw NAL packet bytes,
// MSB first, last_byte set on the final byte. Output channel (o_out_valid /
// i_out_ready / o_out_data): one summary per packet, produced on its last
// byte: status, key SPS fields and the cropped picture size.
// Start code and NAL header bytes are checked as they are accepted. The
// walker consumes one bitstream bit per cycle, the first bit of a payload
// byte in the accepting cycle; the next byte is taken only once all its bits
// are consumed. After the last byte a short or rejected packet goes from
// S_FIN to S_OUT, a parsed SPS first to S_SIZE (crop arithmetic unit).
// The output register holds the summary while the receiver stalls and the
// next packet's bytes are accepted meanwhile; only a second summary waits
// for the first to be taken. Reset (synchronous, active low) empties the
// output register and returns the block to the start code check.
// CODE_BITS caps the Exp-Golomb prefix.
`default_nettype none

module h264_sps_header_parser #(
    parameter int CODE_BITS = 32
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire sps_pkg::t_in   i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output sps_pkg::t_out       o_out_data
);

    localparam logic [2:0] POS_SC_LAST = 3'd3;
    localparam logic [2:0] POS_NAL = 3'd4;
    localparam logic [2:0] POS_PAYLOAD = 3'd5;

    typedef enum logic [2:0] {S_IDLE, S_BITS, S_FIN, S_SIZE, S_OUT} t_state;

    t_state         r_state, n_state;
    logic [2:0]     r_pos, n_pos;
    logic [23:0]    r_window, n_window;
    logic           r_fail, n_fail;
    logic           r_last, n_last;
    logic [6:0]     r_shift, n_shift;
    logic [2:0]     r_bitcnt, n_bitcnt;
    logic [1:0]     r_stat, n_stat;
    logic           r_out_valid, n_out_valid;
    sps_pkg::t_out  r_out, n_out;

    logic             w_in_acc;
    logic [31:0]      w_full;
    logic             w_seq_start;
    logic             w_bit_valid;
    logic             w_bit;
    logic             w_size_start;
    logic             w_seq_done;
    logic             w_size_done;
    logic [15:0]      w_width, w_height;
    sps_pkg::t_fields w_fields;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc = i_in_valid && o_in_ready;
    assign w_full = {r_window, i_in_data.data_byte};

    // first payload bit goes straight from the input, the rest from r_shift
    assign w_bit_valid = (r_state == S_BITS) ||
                         (w_in_acc && !r_fail && (r_pos == POS_PAYLOAD));
    assign w_bit = (r_state == S_BITS) ? r_shift[6] : i_in_data.data_byte[7];

    sps_seq #(
        .CODE_BITS (CODE_BITS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_seq_start),
        .i_bit_valid (w_bit_valid),
        .i_bit       (w_bit),
        .o_fields    (w_fields),
        .o_done      (w_seq_done)
    );

    sps_size u_size (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_size_start),
        .i_fields (w_fields),
        .o_done   (w_size_done),
        .o_width  (w_width),
        .o_height (w_height)
    );

    // control: header check, bit feed, summary
    always_comb begin
        n_state = r_state;
        n_pos = r_pos;
        n_window = r_window;
        n_fail = r_fail;
        n_last = r_last;
        n_shift = r_shift;
        n_bitcnt = r_bitcnt;
        n_stat = r_stat;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out = r_out;
        w_seq_start = 1'b0;
        w_size_start = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_last = i_in_data.last_byte;
                    if (i_in_data.last_byte) begin
                        n_state = S_FIN;
                    end
                    if (!r_fail) begin
                        if (r_pos < POS_NAL) begin
                            n_window = w_full[23:0];
                            n_pos = r_pos + 3'd1;
                            if (r_pos == POS_SC_LAST) begin
                                if (w_full == sps_pkg::START_CODE4) begin
                                    // NAL header is the next byte
                                end else if (w_full[31:8] == sps_pkg::START_CODE3) begin
                                    if (w_full[4:0] == sps_pkg::NAL_TYPE_SPS) begin
                                        n_pos = POS_PAYLOAD;
                                        w_seq_start = 1'b1;
                                    end else begin
                                        n_fail = 1'b1;
                                    end
                                end else begin
                                    n_fail = 1'b1;
                                end
                            end
                        end else if (r_pos == POS_NAL) begin
                            if (i_in_data.data_byte[4:0] == sps_pkg::NAL_TYPE_SPS) begin
                                n_pos = POS_PAYLOAD;
                                w_seq_start = 1'b1;
                            end else begin
                                n_fail = 1'b1;
                            end
                        end else begin
                            n_shift = i_in_data.data_byte[6:0];
                            n_bitcnt = 3'd6;
                            n_state = S_BITS;
                        end
                    end
                end
            end
            S_BITS: begin
                n_shift = {r_shift[5:0], 1'b0};
                n_bitcnt = r_bitcnt - 3'd1;
                if (r_bitcnt == '0) begin
                    n_state = r_last ? S_FIN : S_IDLE;
                end
            end
            S_FIN: begin
                if (r_fail || (r_pos != POS_PAYLOAD)) begin
                    n_stat = sps_pkg::STAT_BAD;
                    n_state = S_OUT;
                end else if (w_seq_done) begin
                    n_stat = sps_pkg::STAT_OK;
                    w_size_start = 1'b1;
                    n_state = S_SIZE;
                end else begin
                    n_stat = sps_pkg::STAT_SHORT;
                    n_state = S_OUT;
                end
            end
            S_SIZE: begin
                if (w_size_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out = '0;
                    n_out.status = r_stat;
                    if (r_stat == sps_pkg::STAT_OK) begin
                        n_out.profile_idc = w_fields.profile_idc;
                        n_out.level_idc = w_fields.level_idc;
                        n_out.sps_id = w_fields.sps_id;
                        n_out.chroma_format = w_fields.chroma_format;
                        n_out.luma_depth_minus8 = w_fields.luma_depth_minus8;
                        n_out.chroma_depth_minus8 = w_fields.chroma_depth_minus8;
                        n_out.poc_type = w_fields.poc_type;
                        n_out.max_ref_frames = w_fields.max_ref_frames;
                        n_out.frame_only = w_fields.frame_only;
                        n_out.pic_width = w_width;
                        n_out.pic_height = w_height;
                    end
                    n_out_valid = 1'b1;
                    n_pos = '0;
                    n_fail = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pos <= '0;
            r_fail <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos <= n_pos;
            r_fail <= n_fail;
            r_out_valid <= n_out_valid;
        end
        r_window <= n_window;
        r_last <= n_last;
        r_shift <= n_shift;
        r_bitcnt <= n_bitcnt;
        r_stat <= n_stat;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out;

    // a failed or short packet reports no fields
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status != sps_pkg::STAT_OK)) |->
        ((o_out_data.pic_width == '0) && (o_out_data.pic_height == '0) &&
         (o_out_data.profile_idc == '0)))
        else $error("non-OK summary carries field data");

    // only defined status codes leave the block
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.status == sps_pkg::STAT_OK) ||
                         (o_out_data.status == sps_pkg::STAT_BAD) ||
                         (o_out_data.status == sps_pkg::STAT_SHORT)))
        else $error("undefined status code");

    // bits reach the walker only after a good SPS header
    a_bits_after_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_bit_valid |-> ((r_pos == POS_PAYLOAD) && !r_fail))
        else $error("payload bit fed outside the SPS payload");

    // the size unit finishes only while the controller waits for it
    a_size_in_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_size_done |-> (r_state == S_SIZE))
        else $error("size result arrived out of sequence");

endmodule

`default_nettype wire
